// File: src/mesh_unit_cube_normalizer_core_defines.svh
// Assertion macros shared by the unit cube normaliser RTL.
// Expects signals named clock and reset in the scope of each use.
`ifndef MESH_UNIT_CUBE_NORMALIZER_CORE_DEFINES_SVH
`define MESH_UNIT_CUBE_NORMALIZER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define MUCN_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mucn: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define MUCN_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mucn: next-cycle check failed");

`endif

// File: src/mucn_pkg.sv
// Types, widths and codes for the unit cube normaliser.
// No dependencies; used by the interfaces, the divider and the top level.
`default_nettype none

package mucn_pkg;

   localparam int KIND_W  = 2;
   localparam int COORD_W = 32;
   localparam int NRM_W   = 16;
   localparam int OUT_W   = 32;
   localparam int SUM_W   = COORD_W + 1;   // low + high, exact
   localparam int EXT_W   = COORD_W + 1;   // box extent
   localparam int MAG_W   = COORD_W + 2;   // |2*pos - (low + high)| and 2*extent
   localparam int DIFF_W  = COORD_W + 3;   // signed 2*pos - (low + high)
   localparam int QUOT_W  = OUT_W + 1;     // quotient bits produced per axis

   localparam logic [KIND_W-1:0] KIND_WIDEN = 2'd0;
   localparam logic [KIND_W-1:0] KIND_NORM  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [NRM_W-1:0]   nrm_type;

   localparam coord_type COORD_MAX = 32'sh7FFF_FFFF;
   localparam coord_type COORD_MIN = 32'sh8000_0000;

   // Saturation limits on the quotient magnitude
   localparam logic [QUOT_W-1:0] SAT_POS = 33'h0_7FFF_FFFF;
   localparam logic [QUOT_W-1:0] SAT_NEG = 33'h0_8000_0000;

   typedef struct packed {
      logic             start;
      logic [MAG_W-1:0] dividend;
      logic [MAG_W-1:0] divisor;
   } div_ctrl_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic              ovf;
      logic [QUOT_W-1:0] quot;
   } div_stat_type;

endpackage

`default_nettype wire

// File: src/mucn_req_if.sv
// Request channel of the unit cube normaliser: valid/ready plus vertex payload.
// Depends on mucn_pkg.
`default_nettype none

interface mucn_req_if;
   import mucn_pkg::*;

   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   coord_type           pos_x;
   coord_type           pos_y;
   coord_type           pos_z;
   nrm_type             facet_nx;
   nrm_type             facet_ny;
   nrm_type             facet_nz;

   modport source (output valid, kind, pos_x, pos_y, pos_z, facet_nx, facet_ny, facet_nz,
                   input ready);
   modport sink   (input valid, kind, pos_x, pos_y, pos_z, facet_nx, facet_ny, facet_nz,
                   output ready);
endinterface

`default_nettype wire

// File: src/mucn_rsp_if.sv
// Response channel of the unit cube normaliser: valid/ready plus result payload.
// Depends on mucn_pkg.
`default_nettype none

interface mucn_rsp_if;
   import mucn_pkg::*;

   logic                   valid;
   logic                   ready;
   logic signed [OUT_W-1:0] norm_x;
   logic signed [OUT_W-1:0] norm_y;
   logic signed [OUT_W-1:0] norm_z;
   nrm_type                out_nx;
   nrm_type                out_ny;
   nrm_type                out_nz;
   logic                   degenerate;

   modport source (output valid, norm_x, norm_y, norm_z, out_nx, out_ny, out_nz, degenerate,
                   input ready);
   modport sink   (input valid, norm_x, norm_y, norm_z, out_nx, out_ny, out_nz, degenerate,
                   output ready);
endinterface

`default_nettype wire

// File: src/mucn_div.sv
// Restoring divider, one quotient bit per cycle: floor(dividend * 2^F / divisor).
// Flags quotients of 2^QUOT_W or more. Depends on mucn_pkg.
`default_nettype none

module mucn_div #(
   parameter int OUT_FRAC_BITS = 30
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire mucn_pkg::div_ctrl_type ctrl,
   output      mucn_pkg::div_stat_type stat
);
   import mucn_pkg::*;

   localparam int NUM_W = MAG_W + OUT_FRAC_BITS;
   localparam int CNT_W = $clog2(QUOT_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QUOT_W - 1);

   logic [NUM_W-1:0]  num_full;
   logic [MAG_W-1:0]  rem_init;
   logic [MAG_W+1:0]  trial;
   logic              trial_ge;

   logic [MAG_W-1:0]  rem_ff, rem_in;
   logic [MAG_W-1:0]  dsr_ff, dsr_in;
   logic [QUOT_W-1:0] feed_ff, feed_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic              ovf_ff, ovf_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   // Scaled numerator; the top bits seed the remainder, the rest feed in serially
   assign num_full = {ctrl.dividend, OUT_FRAC_BITS'(0)};
   assign rem_init = MAG_W'(num_full[NUM_W-1:QUOT_W]);

   // Shared trial subtract
   assign trial    = {1'b0, rem_ff, feed_ff[QUOT_W-1]} - {2'b00, dsr_ff};
   assign trial_ge = ~trial[MAG_W+1];

   // Sequencing of one division
   always_comb begin
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      feed_in = feed_ff;
      quot_in = quot_ff;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         rem_in  = rem_init;
         dsr_in  = ctrl.divisor;
         feed_in = num_full[QUOT_W-1:0];
         quot_in = '0;
         ovf_in  = (rem_init >= ctrl.divisor);
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial_ge) begin
            rem_in = trial[MAG_W-1:0];
         end else begin
            rem_in = {rem_ff[MAG_W-2:0], feed_ff[QUOT_W-1]};
         end
         quot_in = {quot_ff[QUOT_W-2:0], trial_ge};
         feed_in = {feed_ff[QUOT_W-2:0], 1'b0};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      feed_ff <= feed_in;
      quot_ff <= quot_in;
      ovf_ff  <= ovf_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign stat.ovf  = ovf_ff;
   assign stat.quot = quot_ff;

endmodule

`default_nettype wire

// File: src/mesh_unit_cube_normalizer_core.sv
// Mesh unit cube normaliser: bounding box tracking and centre/scale normalisation.
// Two passes over a mesh: widen requests build the box, normalise requests map a
// vertex into Q1.OUT_FRAC_BITS. Clock is clock, reset is synchronous active high.
// req_chan (sink): one request per valid & ready. kind 0 widens the box and kind 2
// clears it, both in the accepting cycle with no response; kind 3 is ignored.
// kind 1 produces one response on rsp_chan (source) with the centred, scaled
// position, the facet normal copied through and a degenerate flag (empty box or
// zero extent, positions zero).
// A kind 1 request first scans the extent over the three axes, then per axis runs centre
// sum, difference, divider start, 33 quotient bits and capture on the single shared
// divider, then moves the result into the output register; a degenerate box skips the
// divider. ready is low during that work, so no new request is taken until it ends;
// widen and clear requests go at one per cycle while the core is idle.
// The output register lets the next request be taken while a response waits; if
// the receiver stalls, a finished normalisation holds in its last state until the
// output register frees up. Reset empties the box and drops any pending response.
`default_nettype none
`include "mesh_unit_cube_normalizer_core_defines.svh"

module mesh_unit_cube_normalizer_core #(
   parameter int OUT_FRAC_BITS = 30
) (
   input  wire logic   clock,
   input  wire logic   reset,
   mucn_req_if.sink    req_chan,
   mucn_rsp_if.source  rsp_chan
);
   import mucn_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EXT   = 3'd1;
   localparam logic [2:0] ST_SUM   = 3'd2;
   localparam logic [2:0] ST_DIFF  = 3'd3;
   localparam logic [2:0] ST_START = 3'd4;
   localparam logic [2:0] ST_DIV   = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;

   localparam logic [1:0] LAST_AXIS = 2'd2;

   // Control
   logic [2:0] state_ff, state_in;
   logic [1:0] axis_ff, axis_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // Box
   coord_type  low_ff [3];
   coord_type  low_in [3];
   coord_type  high_ff [3];
   coord_type  high_in [3];

   // Work registers
   coord_type          pos_ff [3];
   coord_type          pos_in [3];
   nrm_type            nrm_ff [3];
   nrm_type            nrm_in [3];
   logic [EXT_W-1:0]   ext_ff, ext_in;
   logic               empty_ff, empty_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [MAG_W-1:0]   mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic [OUT_W-1:0]   res_ff [3];
   logic [OUT_W-1:0]   res_in [3];
   logic               degen_ff, degen_in;

   // Output register
   logic [OUT_W-1:0]   out_norm_ff [3];
   logic [OUT_W-1:0]   out_norm_in [3];
   nrm_type            out_nrm_ff [3];
   nrm_type            out_nrm_in [3];
   logic               out_degen_ff, out_degen_in;

   // Datapath nets
   logic               req_take;
   logic [EXT_W-1:0]   span;
   logic               span_neg;
   logic [EXT_W-1:0]   ext_next;
   logic               empty_next;
   logic [DIFF_W-1:0]  two_pos;
   logic [DIFF_W-1:0]  sum_ext;
   logic [DIFF_W-1:0]  pos_minus;
   logic [DIFF_W-1:0]  sum_minus;
   logic [QUOT_W-1:0]  lim;
   logic               sat;
   logic [QUOT_W-1:0]  q_sel;
   logic [OUT_W-1:0]   q_signed;
   logic               out_free;
   logic               degen_norm_zero;

   div_ctrl_type       div_ctrl;
   div_stat_type       div_stat;

   mucn_div #(
      .OUT_FRAC_BITS (OUT_FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .ctrl  (div_ctrl),
      .stat  (div_stat)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   // Extent scan: one axis per cycle
   assign span       = {high_ff[axis_ff][COORD_W-1], high_ff[axis_ff]}
                     - {low_ff[axis_ff][COORD_W-1], low_ff[axis_ff]};
   assign span_neg   = span[EXT_W-1];
   assign ext_next   = (!span_neg && (span > ext_ff)) ? span : ext_ff;
   assign empty_next = empty_ff || span_neg;

   // Centred difference, both signs in parallel
   assign two_pos   = {{2{pos_ff[axis_ff][COORD_W-1]}}, pos_ff[axis_ff], 1'b0};
   assign sum_ext   = {{2{sum_ff[SUM_W-1]}}, sum_ff};
   assign pos_minus = two_pos - sum_ext;
   assign sum_minus = sum_ext - two_pos;

   // Divider hookup
   assign div_ctrl.start    = (state_ff == ST_START);
   assign div_ctrl.dividend = mag_ff;
   assign div_ctrl.divisor  = {ext_ff, 1'b0};

   // Saturate and apply sign
   assign lim      = neg_ff ? SAT_NEG : SAT_POS;
   assign sat      = div_stat.ovf || (div_stat.quot > lim);
   assign q_sel    = sat ? lim : div_stat.quot;
   assign q_signed = neg_ff ? (OUT_W'(0) - q_sel[OUT_W-1:0]) : q_sel[OUT_W-1:0];

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      ext_in       = ext_ff;
      empty_in     = empty_ff;
      sum_in       = sum_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      degen_in     = degen_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      out_degen_in = out_degen_ff;
      for (int i = 0; i < 3; i++) begin
         low_in[i]      = low_ff[i];
         high_in[i]     = high_ff[i];
         pos_in[i]      = pos_ff[i];
         nrm_in[i]      = nrm_ff[i];
         res_in[i]      = res_ff[i];
         out_norm_in[i] = out_norm_ff[i];
         out_nrm_in[i]  = out_nrm_ff[i];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               unique case (req_chan.kind)
                  KIND_WIDEN: begin
                     if (req_chan.pos_x < low_ff[0])  low_in[0]  = req_chan.pos_x;
                     if (req_chan.pos_y < low_ff[1])  low_in[1]  = req_chan.pos_y;
                     if (req_chan.pos_z < low_ff[2])  low_in[2]  = req_chan.pos_z;
                     if (req_chan.pos_x > high_ff[0]) high_in[0] = req_chan.pos_x;
                     if (req_chan.pos_y > high_ff[1]) high_in[1] = req_chan.pos_y;
                     if (req_chan.pos_z > high_ff[2]) high_in[2] = req_chan.pos_z;
                  end
                  KIND_CLEAR: begin
                     for (int i = 0; i < 3; i++) begin
                        low_in[i]  = COORD_MAX;
                        high_in[i] = COORD_MIN;
                     end
                  end
                  KIND_NORM: begin
                     pos_in[0] = req_chan.pos_x;
                     pos_in[1] = req_chan.pos_y;
                     pos_in[2] = req_chan.pos_z;
                     nrm_in[0] = req_chan.facet_nx;
                     nrm_in[1] = req_chan.facet_ny;
                     nrm_in[2] = req_chan.facet_nz;
                     ext_in    = '0;
                     empty_in  = 1'b0;
                     axis_in   = '0;
                     state_in  = ST_EXT;
                  end
                  default: begin
                     // unused kind: no effect
                  end
               endcase
            end
         end
         ST_EXT: begin
            ext_in   = ext_next;
            empty_in = empty_next;
            if (axis_ff == LAST_AXIS) begin
               axis_in = '0;
               if (empty_next || (ext_next == '0)) begin
                  for (int i = 0; i < 3; i++) res_in[i] = '0;
                  degen_in = 1'b1;
                  state_in = ST_OUT;
               end else begin
                  degen_in = 1'b0;
                  state_in = ST_SUM;
               end
            end else begin
               axis_in = axis_ff + 2'd1;
            end
         end
         ST_SUM: begin
            sum_in   = {low_ff[axis_ff][COORD_W-1], low_ff[axis_ff]}
                     + {high_ff[axis_ff][COORD_W-1], high_ff[axis_ff]};
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            neg_in   = pos_minus[DIFF_W-1];
            mag_in   = pos_minus[DIFF_W-1] ? sum_minus[MAG_W-1:0] : pos_minus[MAG_W-1:0];
            state_in = ST_START;
         end
         ST_START: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done) begin
               res_in[axis_ff] = q_signed;
               if (axis_ff == LAST_AXIS) begin
                  state_in = ST_OUT;
               end else begin
                  axis_in  = axis_ff + 2'd1;
                  state_in = ST_SUM;
               end
            end
         end
         ST_OUT: begin
            if (out_free) begin
               for (int i = 0; i < 3; i++) begin
                  out_norm_in[i] = res_ff[i];
                  out_nrm_in[i]  = nrm_ff[i];
               end
               out_degen_in = degen_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state and box
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            low_ff[i]  <= COORD_MAX;
            high_ff[i] <= COORD_MIN;
         end
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < 3; i++) begin
            low_ff[i]  <= low_in[i];
            high_ff[i] <= high_in[i];
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      ext_ff       <= ext_in;
      empty_ff     <= empty_in;
      sum_ff       <= sum_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      degen_ff     <= degen_in;
      out_degen_ff <= out_degen_in;
      for (int i = 0; i < 3; i++) begin
         pos_ff[i]      <= pos_in[i];
         nrm_ff[i]      <= nrm_in[i];
         res_ff[i]      <= res_in[i];
         out_norm_ff[i] <= out_norm_in[i];
         out_nrm_ff[i]  <= out_nrm_in[i];
      end
   end

   // Response channel
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.norm_x     = out_norm_ff[0];
   assign rsp_chan.norm_y     = out_norm_ff[1];
   assign rsp_chan.norm_z     = out_norm_ff[2];
   assign rsp_chan.out_nx     = out_nrm_ff[0];
   assign rsp_chan.out_ny     = out_nrm_ff[1];
   assign rsp_chan.out_nz     = out_nrm_ff[2];
   assign rsp_chan.degenerate = out_degen_ff;

   // All positions zero in the output register
   assign degen_norm_zero = (out_norm_ff[0] == '0) && (out_norm_ff[1] == '0)
                         && (out_norm_ff[2] == '0);

   // Checks
   `MUCN_ASSERT_IMP(a_start_when_free, div_ctrl.start, !div_stat.busy)
   `MUCN_ASSERT_IMP(a_done_while_waiting, div_stat.done, state_ff == ST_DIV)
   `MUCN_ASSERT_IMP(a_degen_zero, rsp_valid_ff && out_degen_ff, degen_norm_zero)
   `MUCN_ASSERT_NEXT(a_norm_holds_off, req_take && (req_chan.kind == KIND_NORM), !req_chan.ready)

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for mesh_unit_cube_normalizer_core: builds random meshes,
// predicts each normalised vertex in a bounding-box scoreboard and checks responses.
// Depends on mucn_pkg and the mucn_req_if / mucn_rsp_if interfaces.

module tb_top;
   import mucn_pkg::*;

   localparam int OUT_FRAC_BITS   = 30;
   localparam int TOTAL_ITEMS     = 1850;
   localparam int STEADY_FROM     = 500;
   localparam int STEADY_TO       = 800;
   localparam int HOLD_AT         = 1100;
   localparam int PAUSE_AT        = 1500;
   localparam int HOLD_OFF_CYCLES = 600;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int DRAIN_CYCLES    = 150;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      coord_type         pos_x;
      coord_type         pos_y;
      coord_type         pos_z;
      nrm_type           facet_nx;
      nrm_type           facet_ny;
      nrm_type           facet_nz;
   } vertex_request_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] norm_x;
      logic signed [OUT_W-1:0] norm_y;
      logic signed [OUT_W-1:0] norm_z;
      nrm_type                 out_nx;
      nrm_type                 out_ny;
      nrm_type                 out_nz;
      logic                    degenerate;
   } vertex_result_type;

   // Bounding box tracker and queue of expected normalised vertices
   class unit_cube_scoreboard;
      coord_type         low_x, low_y, low_z;
      coord_type         high_x, high_y, high_z;
      vertex_result_type expected_norms[$];
      int unsigned       failures;

      function new();
         clear_box();
         failures = 0;
      endfunction

      function void clear_box();
         low_x  = COORD_MAX;
         low_y  = COORD_MAX;
         low_z  = COORD_MAX;
         high_x = COORD_MIN;
         high_y = COORD_MIN;
         high_z = COORD_MIN;
      endfunction

      // (2*pos - (lo + hi)) / (2*extent) in Q1.OUT_FRAC_BITS, truncated, saturated
      function logic [OUT_W-1:0] scale_axis(coord_type pos, coord_type lo, coord_type hi,
                                            longint extent);
         longint      diff;
         logic [63:0] mag, divisor, whole, rem, lim, quot;
         diff    = 2 * longint'(pos) - (longint'(lo) + longint'(hi));
         mag     = (diff < 0) ? 64'(-diff) : 64'(diff);
         divisor = 64'(extent) << 1;
         whole   = mag / divisor;
         rem     = mag % divisor;
         lim     = (diff < 0) ? 64'h8000_0000 : 64'h7FFF_FFFF;
         if (whole > (lim >> OUT_FRAC_BITS)) begin
            quot = lim;
         end else begin
            quot = (whole << OUT_FRAC_BITS) + ((rem << OUT_FRAC_BITS) / divisor);
            if (quot > lim) quot = lim;
         end
         if (diff < 0) quot = -quot;
         return quot[OUT_W-1:0];
      endfunction

      function void note_request(vertex_request_type req);
         vertex_result_type res;
         longint            ext_x, ext_y, ext_z, extent;
         case (req.kind)
            KIND_WIDEN: begin
               if (req.pos_x < low_x)  low_x  = req.pos_x;
               if (req.pos_y < low_y)  low_y  = req.pos_y;
               if (req.pos_z < low_z)  low_z  = req.pos_z;
               if (req.pos_x > high_x) high_x = req.pos_x;
               if (req.pos_y > high_y) high_y = req.pos_y;
               if (req.pos_z > high_z) high_z = req.pos_z;
            end
            KIND_CLEAR: clear_box();
            KIND_NORM: begin
               res            = '0;
               res.out_nx     = req.facet_nx;
               res.out_ny     = req.facet_ny;
               res.out_nz     = req.facet_nz;
               res.degenerate = 1'b1;
               if (low_x <= high_x && low_y <= high_y && low_z <= high_z) begin
                  ext_x  = longint'(high_x) - longint'(low_x);
                  ext_y  = longint'(high_y) - longint'(low_y);
                  ext_z  = longint'(high_z) - longint'(low_z);
                  extent = ext_x;
                  if (ext_y > extent) extent = ext_y;
                  if (ext_z > extent) extent = ext_z;
                  if (extent != 0) begin
                     res.norm_x     = scale_axis(req.pos_x, low_x, high_x, extent);
                     res.norm_y     = scale_axis(req.pos_y, low_y, high_y, extent);
                     res.norm_z     = scale_axis(req.pos_z, low_z, high_z, extent);
                     res.degenerate = 1'b0;
                  end
               end
               expected_norms = {expected_norms, res};
            end
            default: ;  // unused kind: no effect
         endcase
      endfunction

      function int pending();
         return expected_norms.size();
      endfunction

      function void compare_field(string name, longint want, longint got);
         if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            failures++;
         end
      endfunction

      function void check_result(vertex_result_type got);
         vertex_result_type want;
         if (expected_norms.size() == 0) begin
            $error("response with no request outstanding");
            failures++;
            return;
         end
         want = expected_norms.pop_front();
         compare_field("norm_x", want.norm_x, got.norm_x);
         compare_field("norm_y", want.norm_y, got.norm_y);
         compare_field("norm_z", want.norm_z, got.norm_z);
         compare_field("out_nx", want.out_nx, got.out_nx);
         compare_field("out_ny", want.out_ny, got.out_ny);
         compare_field("out_nz", want.out_nz, got.out_nz);
         compare_field("degenerate", want.degenerate, got.degenerate);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   bit          steady_run   = 1'b0;
   bit          hold_request = 1'b0;
   int unsigned items_sent   = 0;

   unit_cube_scoreboard box_sb = new();

   mucn_req_if req_chan ();
   mucn_rsp_if rsp_chan ();

   mesh_unit_cube_normalizer_core #(
      .OUT_FRAC_BITS(OUT_FRAC_BITS)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Note every accepted request in the scoreboard
   always @(posedge clock) begin : req_monitor
      vertex_request_type seen;
      if (!reset && req_chan.valid && req_chan.ready) begin
         seen.kind     = req_chan.kind;
         seen.pos_x    = req_chan.pos_x;
         seen.pos_y    = req_chan.pos_y;
         seen.pos_z    = req_chan.pos_z;
         seen.facet_nx = req_chan.facet_nx;
         seen.facet_ny = req_chan.facet_ny;
         seen.facet_nz = req_chan.facet_nz;
         box_sb.note_request(seen);
      end
   end

   // Check every accepted response
   always @(posedge clock) begin : rsp_monitor
      vertex_result_type seen;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         seen.norm_x     = rsp_chan.norm_x;
         seen.norm_y     = rsp_chan.norm_y;
         seen.norm_z     = rsp_chan.norm_z;
         seen.out_nx     = rsp_chan.out_nx;
         seen.out_ny     = rsp_chan.out_ny;
         seen.out_nz     = rsp_chan.out_nz;
         seen.degenerate = rsp_chan.degenerate;
         box_sb.check_result(seen);
      end
   end

   // Receiver: random back-pressure, plus one long hold-off on request
   initial begin : rsp_side
      bit hold_taken;
      hold_taken     = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_taken) begin
            rsp_chan.ready = 1'b0;
            hold_taken     = 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         rsp_chan.ready = steady_run || ($urandom_range(99) >= 31);
      end
   end

   // Watchdog: too long without any handshake ends the run
   initial begin : watchdog
      int quiet;
      quiet = 0;
      wait (!reset);
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("TEST FAILED");
      $finish;
   end

   function automatic vertex_request_type make_request(logic [KIND_W-1:0] kind,
         coord_type x, coord_type y, coord_type z,
         nrm_type nx = '0, nrm_type ny = '0, nrm_type nz = '0);
      vertex_request_type req;
      req.kind     = kind;
      req.pos_x    = x;
      req.pos_y    = y;
      req.pos_z    = z;
      req.facet_nx = nx;
      req.facet_ny = ny;
      req.facet_nz = nz;
      return req;
   endfunction

   // Mix of extremes, full-range and small Q16.16 values
   function automatic coord_type random_coord();
      case ($urandom_range(7))
         0:       return COORD_MIN;
         1:       return COORD_MAX;
         2:       return coord_type'($urandom);
         default: return $signed($urandom) >>> $urandom_range(31);
      endcase
   endfunction

   function automatic nrm_type random_normal();
      return nrm_type'($urandom);
   endfunction

   // Sender pause: drop valid and wait for every outstanding response
   task automatic wait_for_results();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (box_sb.pending() != 0) @(posedge clock);
   endtask

   task automatic offer_request(input vertex_request_type item);
      @(negedge clock);
      if (!steady_run) begin
         while ($urandom_range(99) < 31) begin
            req_chan.valid = 1'b0;
            @(negedge clock);
         end
      end
      req_chan.kind     = item.kind;
      req_chan.pos_x    = item.pos_x;
      req_chan.pos_y    = item.pos_y;
      req_chan.pos_z    = item.pos_z;
      req_chan.facet_nx = item.facet_nx;
      req_chan.facet_ny = item.facet_ny;
      req_chan.facet_nz = item.facet_nz;
      req_chan.valid    = 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      // ignored kinds do not count towards the run length
      if (item.kind != KIND_UNUSED) begin
         items_sent++;
         case (items_sent)
            STEADY_FROM: steady_run   = 1'b1;
            STEADY_TO:   steady_run   = 1'b0;
            HOLD_AT:     hold_request = 1'b1;
            PAUSE_AT:    wait_for_results();
            default: ;
         endcase
      end
   endtask

   initial begin : stimulus
      vertex_request_type item;
      vertex_request_type mesh_verts[$];
      req_chan.valid    = 1'b0;
      req_chan.kind     = KIND_WIDEN;
      req_chan.pos_x    = '0;
      req_chan.pos_y    = '0;
      req_chan.pos_z    = '0;
      req_chan.facet_nx = '0;
      req_chan.facet_ny = '0;
      req_chan.facet_nz = '0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty box straight after reset, unused kind
      offer_request(make_request(KIND_NORM, COORD_MIN, COORD_MAX, 0, -32768, 32767, 0));
      offer_request(make_request(KIND_UNUSED, -1, -1, -1, -1, -1, -1));
      // zero extent
      offer_request(make_request(KIND_WIDEN, 0, 0, 0));
      offer_request(make_request(KIND_NORM, 0, 0, 0, 32767, -32768, -1));
      // full-range box
      offer_request(make_request(KIND_WIDEN, COORD_MIN, COORD_MIN, COORD_MIN, -1, -1, -1));
      offer_request(make_request(KIND_WIDEN, COORD_MAX, COORD_MAX, COORD_MAX));
      offer_request(make_request(KIND_NORM, COORD_MAX, COORD_MIN, 0, -1, -1, -1));
      offer_request(make_request(KIND_NORM, 0, 0, 0, 1, 2, 3));
      // empty again after a clear
      offer_request(make_request(KIND_CLEAR, -1, -1, -1, -1, -1, -1));
      offer_request(make_request(KIND_NORM, 5, 6, 7, 100, -100, 0));
      // one-LSB box: vertices far outside saturate both ways
      offer_request(make_request(KIND_WIDEN, 0, 0, 0));
      offer_request(make_request(KIND_WIDEN, 1, 0, 0));
      offer_request(make_request(KIND_NORM, COORD_MAX, COORD_MIN, 1, 16384, -16384, 0));
      offer_request(make_request(KIND_NORM, 1, 0, -1));
      offer_request(make_request(KIND_UNUSED, 3, 3, 3));
      offer_request(make_request(KIND_NORM, 0, 1, 0));
      // ordinary Q16.16 mesh
      offer_request(make_request(KIND_CLEAR, 0, 0, 0));
      offer_request(make_request(KIND_WIDEN, -3 * 65536, 5 * 65536, 100));
      offer_request(make_request(KIND_WIDEN, 7 * 65536, -65536, -100));
      offer_request(make_request(KIND_NORM, 65536, 0, 0, 11, 22, 33));
      offer_request(make_request(KIND_NORM, -3 * 65536, 5 * 65536, -100));
      offer_request(make_request(KIND_CLEAR, COORD_MAX, COORD_MAX, COORD_MAX));
      wait_for_results();

      // Random: mostly complete meshes (clear, widen pass, normalise pass), some noise
      while (items_sent < TOTAL_ITEMS) begin
         if ($urandom_range(99) < 80) begin
            if ($urandom_range(99) < 70) begin
               offer_request(make_request(KIND_CLEAR, random_coord(), random_coord(),
                  random_coord(), random_normal(), random_normal(), random_normal()));
               mesh_verts.delete();
            end
            repeat ($urandom_range(1, 6)) begin
               item = make_request(KIND_WIDEN, random_coord(), random_coord(),
                  random_coord(), random_normal(), random_normal(), random_normal());
               mesh_verts = {mesh_verts, item};
               offer_request(item);
            end
            repeat ($urandom_range(1, 5)) begin
               if (mesh_verts.size() != 0 && $urandom_range(99) < 60)
                  item = mesh_verts[$urandom_range(mesh_verts.size() - 1)];
               else
                  item = make_request(KIND_NORM, random_coord(), random_coord(),
                     random_coord());
               item.kind     = KIND_NORM;
               item.facet_nx = random_normal();
               item.facet_ny = random_normal();
               item.facet_nz = random_normal();
               offer_request(item);
            end
         end else begin
            offer_request(make_request(KIND_W'($urandom_range(KIND_UNUSED)),
               random_coord(), random_coord(), random_coord(),
               random_normal(), random_normal(), random_normal()));
         end
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (box_sb.failures == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// File: mesh_unit_cube_normalizer_core.f
+incdir+src
src/mucn_pkg.sv
src/mucn_req_if.sv
src/mucn_rsp_if.sv
src/mucn_div.sv
src/mesh_unit_cube_normalizer_core.sv
tb/tb_top.sv
